### rtl/dcqe_pkg.sv
// ----------------------------------------------------------------------------
// dcqe_pkg
// Shared types and codes of the distinct-class quartet enumerator: word
// layouts of the request, response and configuration channels.
// ----------------------------------------------------------------------------
`default_nettype none

package dcqe_pkg;

    localparam int QUARTET = 4;

    typedef logic [15:0] class_id_t;
    typedef logic [5:0]  item_index_t;
    typedef logic [6:0]  item_count_t;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_NEXT = 1'b1;

    typedef struct packed {
        logic        operation;
        item_index_t item_index;
        class_id_t   class_id;
    } dcqe_req_t;

    typedef struct packed {
        logic        found;
        logic        exhausted;
        item_index_t first_index;
        item_index_t second_index;
        item_index_t third_index;
        item_index_t fourth_index;
    } dcqe_rsp_t;

    typedef struct packed {
        logic                       clash;
        item_index_t [QUARTET-1:0]  order;
    } dcqe_eval_t;

endpackage

`default_nettype wire

### rtl/dcqe_stream_if.sv
// ----------------------------------------------------------------------------
// dcqe_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcqe_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/dcqe_rank_sort.sv
// ----------------------------------------------------------------------------
// dcqe_rank_sort
// Class clash check over four members and ordering of their indices by
// ascending class number.
// ----------------------------------------------------------------------------
`default_nettype none

module dcqe_rank_sort (
    input  dcqe_pkg::class_id_t   key [dcqe_pkg::QUARTET],
    input  dcqe_pkg::item_index_t idx [dcqe_pkg::QUARTET],
    output dcqe_pkg::dcqe_eval_t  result
);
    import dcqe_pkg::*;

    logic [1:0] rank [QUARTET];

    always_comb
    begin
        result = '0;
        for (int p = 0; p < QUARTET; p++)
        begin
            rank[p] = 2'd0;
            for (int q = 0; q < QUARTET; q++)
            begin
                if (q > p && key[q] == key[p])
                begin
                    result.clash = 1'b1;
                end
                if (q != p && key[q] < key[p])
                begin
                    rank[p] = rank[p] + 2'd1;
                end
            end
        end
        // keys are distinct whenever the order is used
        for (int p = 0; p < QUARTET; p++)
        begin
            result.order[QUARTET - 1 - int'(rank[p])] = idx[p];
        end
    end

endmodule

`default_nettype wire

### rtl/distinct_class_quartet_enumerator_unit.sv
// ----------------------------------------------------------------------------
// distinct_class_quartet_enumerator_unit
// Class table with a four-index cursor that walks combinations in
// lexicographic order and returns the next one whose classes all differ.
//
//  channel | direction | word         | notes
//  --------+-----------+--------------+-------------------------------------
//  req     | in        | dcqe_req_t   | load entry or request next quartet
//  rsp     | out       | dcqe_rsp_t   | one word per next request
//  cfg     | in        | item_count_t | always ready; rewinds the cursor
//
// A next request with no combination left is answered without reading the
// table; else each combination examined is handled in two steps: the four
// classes are read through the single table read port, then checked.
// req.ready is held low while a request runs or a response waits
// unconsumed. Reset clears control state only; the class table holds garbage
// until written.
// ----------------------------------------------------------------------------
`default_nettype none

module distinct_class_quartet_enumerator_unit #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    dcqe_stream_if.sink     req,
    dcqe_stream_if.sink     cfg,
    dcqe_stream_if.source   rsp
);
    import dcqe_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS) + 1;
    localparam logic [2:0] FETCH_LAST = 3'(QUARTET);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EVAL
    } state_t;

    typedef logic [CW-1:0] cursor_t;

    state_t      state_reg;
    logic [2:0]  ph_reg;
    cursor_t     cur_reg [QUARTET];
    cursor_t     cur_next [QUARTET];
    logic        adv_ok;
    logic        done_reg;
    item_count_t count_reg;
    class_id_t   key_reg [QUARTET];
    logic        rsp_valid_reg;
    dcqe_rsp_t   rsp_data_reg;

    class_id_t   mem [MAX_ITEMS];
    class_id_t   rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic        wr_en;

    cursor_t     n_act;
    logic        req_fire;
    logic        cfg_fire;
    logic        no_more;
    item_index_t sort_idx [QUARTET];
    dcqe_eval_t  eval;

    assign req_fire = req.valid && req.ready;
    assign cfg_fire = cfg.valid && cfg.ready;

    assign req.ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign cfg.ready = 1'b1;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    assign n_act = (32'(count_reg) > 32'(MAX_ITEMS)) ? CW'(MAX_ITEMS) : CW'(count_reg);
    assign no_more = done_reg || (n_act < CW'(QUARTET)) || (cur_reg[QUARTET-1] >= n_act);

    assign wr_en   = req_fire && (req.data.operation == OP_LOAD)
                     && (32'(req.data.item_index) < 32'(MAX_ITEMS));
    assign wr_addr = AW'(req.data.item_index);
    assign rd_addr = cur_reg[ph_reg[1:0]][AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= req.data.class_id;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // lexicographic step of the cursor
    always_comb
    begin
        cur_next = cur_reg;
        adv_ok   = 1'b1;
        if (cur_reg[3] + CW'(1) < n_act)
        begin
            cur_next[3] = cur_reg[3] + CW'(1);
        end
        else if (cur_reg[2] + CW'(2) < n_act)
        begin
            cur_next[2] = cur_reg[2] + CW'(1);
            cur_next[3] = cur_reg[2] + CW'(2);
        end
        else if (cur_reg[1] + CW'(3) < n_act)
        begin
            cur_next[1] = cur_reg[1] + CW'(1);
            cur_next[2] = cur_reg[1] + CW'(2);
            cur_next[3] = cur_reg[1] + CW'(3);
        end
        else if (cur_reg[0] + CW'(4) < n_act)
        begin
            cur_next[0] = cur_reg[0] + CW'(1);
            cur_next[1] = cur_reg[0] + CW'(2);
            cur_next[2] = cur_reg[0] + CW'(3);
            cur_next[3] = cur_reg[0] + CW'(4);
        end
        else
        begin
            adv_ok = 1'b0;
        end
    end

    always_comb
    begin
        for (int p = 0; p < QUARTET; p++)
        begin
            sort_idx[p] = 6'(cur_reg[p]);
        end
    end

    dcqe_rank_sort u_rank_sort (
        .key    (key_reg),
        .idx    (sort_idx),
        .result (eval)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ph_reg        <= 3'd0;
            done_reg      <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_data_reg  <= '0;
            for (int p = 0; p < QUARTET; p++)
            begin
                cur_reg[p] <= CW'(p);
                key_reg[p] <= '0;
            end
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            if (cfg_fire)
            begin
                count_reg <= cfg.data;
                done_reg  <= 1'b0;
                for (int p = 0; p < QUARTET; p++)
                begin
                    cur_reg[p] <= CW'(p);
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (req_fire)
                    begin
                        if (req.data.operation == OP_LOAD)
                        begin
                            done_reg <= 1'b0;
                            for (int p = 0; p < QUARTET; p++)
                            begin
                                cur_reg[p] <= CW'(p);
                            end
                        end
                        else if (no_more)
                        begin
                            done_reg               <= 1'b1;
                            rsp_valid_reg          <= 1'b1;
                            rsp_data_reg           <= '0;
                            rsp_data_reg.exhausted <= 1'b1;
                        end
                        else
                        begin
                            ph_reg    <= 3'd0;
                            state_reg <= ST_FETCH;
                        end
                    end
                end

                ST_FETCH:
                begin
                    ph_reg <= ph_reg + 3'd1;
                    if (ph_reg != 3'd0)
                    begin
                        key_reg[2'(ph_reg - 3'd1)] <= rd_data_reg;
                    end
                    if (ph_reg == FETCH_LAST)
                    begin
                        state_reg <= ST_EVAL;
                    end
                end

                ST_EVAL:
                begin
                    cur_reg <= cur_next;
                    if (!adv_ok)
                    begin
                        done_reg <= 1'b1;
                    end
                    if (!eval.clash)
                    begin
                        rsp_valid_reg              <= 1'b1;
                        rsp_data_reg.found         <= 1'b1;
                        rsp_data_reg.exhausted     <= !adv_ok;
                        rsp_data_reg.first_index   <= eval.order[3];
                        rsp_data_reg.second_index  <= eval.order[2];
                        rsp_data_reg.third_index   <= eval.order[1];
                        rsp_data_reg.fourth_index  <= eval.order[0];
                        state_reg                  <= ST_IDLE;
                    end
                    else if (!adv_ok)
                    begin
                        rsp_valid_reg          <= 1'b1;
                        rsp_data_reg           <= '0;
                        rsp_data_reg.exhausted <= 1'b1;
                        state_reg              <= ST_IDLE;
                    end
                    else
                    begin
                        ph_reg    <= 3'd0;
                        state_reg <= ST_FETCH;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### sim/dcqe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcqe_checker
// Scoreboard of the distinct-class quartet enumerator. It watches the
// request, configuration and response channels, keeps its own class table,
// item count and quartet cursor, predicts the answer word of each accepted
// next request and compares every response word with the oldest answer.
// ----------------------------------------------------------------------------
module dcqe_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic                  req_ready,
    input  dcqe_pkg::dcqe_req_t   req_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  dcqe_pkg::item_count_t cfg_data,
    input  logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  dcqe_pkg::dcqe_rsp_t   rsp_data,
    output int                    mismatches,
    output int                    pending
);
    import dcqe_pkg::*;

    localparam int TABLE_DEPTH = 64;

    class_id_t   class_mem [TABLE_DEPTH];
    item_index_t walk [QUARTET];
    logic        walk_done;
    item_count_t count_reg;
    dcqe_rsp_t   answer_q [$];

    function automatic void rewind_walk();
        for (int p = 0; p < QUARTET; p++)
        begin
            walk[p] = item_index_t'(p);
        end
        walk_done = 1'b0;
    endfunction

    function automatic bit step_walk(int unsigned n);
        int unsigned a;
        int unsigned b;
        int unsigned c;
        int unsigned d;
        a = walk[0];
        b = walk[1];
        c = walk[2];
        d = walk[3];
        if (d + 1 < n)
        begin
            d++;
        end
        else if (c + 2 < n)
        begin
            c++;
            d = c + 1;
        end
        else if (b + 3 < n)
        begin
            b++;
            c = b + 1;
            d = c + 1;
        end
        else if (a + 4 < n)
        begin
            a++;
            b = a + 1;
            c = b + 1;
            d = c + 1;
        end
        else
        begin
            return 1'b0;
        end
        walk[0] = item_index_t'(a);
        walk[1] = item_index_t'(b);
        walk[2] = item_index_t'(c);
        walk[3] = item_index_t'(d);
        return 1'b1;
    endfunction

    function automatic dcqe_rsp_t next_quartet();
        dcqe_rsp_t   ans;
        int unsigned n;
        item_index_t idx [QUARTET];
        class_id_t   key [QUARTET];
        item_index_t ti;
        class_id_t   tk;
        logic        clash;
        int          q;
        ans = '0;
        n = (count_reg > 7'd64) ? 64 : int'(count_reg);
        if (n < 4 || walk[3] >= n)
            walk_done = 1'b1;
        while (!walk_done)
        begin
            clash = 1'b0;
            for (int p = 0; p < QUARTET; p++)
            begin
                idx[p] = walk[p];
                key[p] = class_mem[walk[p]];
            end
            for (int p = 0; p < QUARTET; p++)
            begin
                for (int r = p + 1; r < QUARTET; r++)
                begin
                    if (key[p] == key[r])
                        clash = 1'b1;
                end
            end
            if (!step_walk(n))
                walk_done = 1'b1;
            if (!clash)
            begin
                for (int p = 1; p < QUARTET; p++)
                begin
                    ti = idx[p];
                    tk = key[p];
                    q = p - 1;
                    while (q >= 0 && key[q] > tk)
                    begin
                        key[q + 1] = key[q];
                        idx[q + 1] = idx[q];
                        q--;
                    end
                    key[q + 1] = tk;
                    idx[q + 1] = ti;
                end
                ans.found        = 1'b1;
                ans.exhausted    = walk_done;
                ans.first_index  = idx[0];
                ans.second_index = idx[1];
                ans.third_index  = idx[2];
                ans.fourth_index = idx[3];
                return ans;
            end
        end
        ans.exhausted = 1'b1;
        return ans;
    endfunction

    task automatic report(string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_answer(dcqe_rsp_t want, dcqe_rsp_t got);
        if (got.found !== want.found)
            report($sformatf("found: want %0d got %0d", want.found, got.found));
        if (got.exhausted !== want.exhausted)
            report($sformatf("exhausted: want %0d got %0d", want.exhausted, got.exhausted));
        if (got.first_index !== want.first_index)
            report($sformatf("first_index: want %0d got %0d",
                             want.first_index, got.first_index));
        if (got.second_index !== want.second_index)
            report($sformatf("second_index: want %0d got %0d",
                             want.second_index, got.second_index));
        if (got.third_index !== want.third_index)
            report($sformatf("third_index: want %0d got %0d",
                             want.third_index, got.third_index));
        if (got.fourth_index !== want.fourth_index)
            report($sformatf("fourth_index: want %0d got %0d",
                             want.fourth_index, got.fourth_index));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  = '0;
            rewind_walk();
            answer_q.delete();
            pending    = 0;
            mismatches = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (answer_q.size() == 0)
                    report("response word with no request waiting");
                else
                    check_answer(answer_q.pop_front(), rsp_data);
            end
            if (cfg_valid && cfg_ready)
            begin
                count_reg = cfg_data;
                rewind_walk();
            end
            if (req_valid && req_ready)
            begin
                if (req_data.operation == OP_LOAD)
                begin
                    class_mem[req_data.item_index] = req_data.class_id;
                    rewind_walk();
                end
                else
                begin
                    answer_q = {answer_q, next_quartet()};
                end
            end
            pending = answer_q.size();
        end
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the distinct-class quartet enumerator. A short
// directed run covers the extreme classes, too few items, the last quartet
// and requests after exhaustion; random phases then set the item count,
// refill the table and issue next requests mixed with stray loads, with
// random gaps on both channels and long response hold-offs.
// ----------------------------------------------------------------------------
module tb_top;
    import dcqe_pkg::*;

    localparam int ITEM_TARGET = 1000;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 20;

    logic clk = 1'b0;
    logic rst_n;

    dcqe_stream_if #(.payload_t(dcqe_req_t))   req_ch ();
    dcqe_stream_if #(.payload_t(item_count_t)) cfg_ch ();
    dcqe_stream_if #(.payload_t(dcqe_rsp_t))   rsp_ch ();

    int         mismatches;
    int         pending;
    int         words_sent = 0;
    int         stall_left = 0;
    bit         idle_on    = 1'b1;
    bit         long_hold  = 1'b0;
    bit         wide_phase = 1'b0;
    class_id_t  class_base = '0;
    int         class_span = 4;

    distinct_class_quartet_enumerator_unit #(
        .MAX_ITEMS (64)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .cfg   (cfg_ch),
        .rsp   (rsp_ch)
    );

    dcqe_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_ch.valid),
        .req_ready  (req_ch.ready),
        .req_data   (req_ch.data),
        .cfg_valid  (cfg_ch.valid),
        .cfg_ready  (cfg_ch.ready),
        .cfg_data   (cfg_ch.data),
        .rsp_valid  (rsp_ch.valid),
        .rsp_ready  (rsp_ch.ready),
        .rsp_data   (rsp_ch.data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic class_id_t class_for(item_index_t idx);
        if (wide_phase)
            return {10'($urandom_range(0, 1023)), idx};
        return class_id_t'(class_base + $urandom_range(0, class_span - 1));
    endfunction

    task automatic send_req(logic op, item_index_t idx, class_id_t cls);
        int        gap;
        dcqe_req_t w;
        gap = pick_gap();
        w.operation  = op;
        w.item_index = idx;
        w.class_id   = cls;
        repeat (gap)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.data  <= w;
        do @(posedge clk); while (!req_ch.ready);
        words_sent++;
    endtask

    task automatic send_next();
        send_req(OP_NEXT, item_index_t'($urandom), class_id_t'($urandom));
    endtask

    // drain all answers and let the last load settle before the write
    task automatic set_count(item_count_t value);
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                rsp_ch.ready <= 1'b1;
                long_hold = 1'b0;
            end
            else if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        int          phase;
        int          n_cfg;
        int          n_act;
        int          ops;
        int          holds_done;
        item_index_t idx;
        phase      = 0;
        holds_done = 0;
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_next();
        send_req(OP_LOAD, 6'd0,  16'h0000);
        send_req(OP_LOAD, 6'd1,  16'hFFFF);
        send_req(OP_LOAD, 6'd2,  16'h1234);
        send_req(OP_LOAD, 6'd3,  16'h00FF);
        send_req(OP_LOAD, 6'd63, 16'hFFFF);
        set_count(7'd3);
        send_next();
        set_count(7'd4);
        send_next();
        send_next();
        send_req(OP_LOAD, 6'd2, 16'h1234);
        send_next();
        send_req(OP_LOAD, 6'd4, 16'h0000);
        send_req(OP_LOAD, 6'd5, 16'h8000);
        set_count(7'd6);
        repeat (7) send_next();

        while (words_sent < ITEM_TARGET)
        begin
            idle_on = ($urandom_range(0, 4) != 0);
            case (phase)
                0: n_cfg = 127;
                1: n_cfg = 64;
                2: n_cfg = 0;
                default:
                begin
                    ops = $urandom_range(0, 99);
                    if (ops < 65)
                        n_cfg = $urandom_range(0, 9);
                    else if (ops < 85)
                        n_cfg = $urandom_range(10, 20);
                    else
                    begin
                        case ($urandom_range(0, 2))
                            0: n_cfg = 64;
                            1: n_cfg = 127;
                            default: n_cfg = $urandom_range(21, 126);
                        endcase
                    end
                end
            endcase
            set_count(item_count_t'(n_cfg));
            n_act      = (n_cfg > 64) ? 64 : n_cfg;
            wide_phase = (n_act > 20);
            class_base = class_id_t'($urandom);
            class_span = $urandom_range(n_act / 2 + 2, n_act + 4);
            for (int i = 0; i < n_act; i++)
            begin
                send_req(OP_LOAD, item_index_t'(i), class_for(item_index_t'(i)));
            end
            if ((holds_done == 0 && words_sent > 300) ||
                (holds_done == 1 && words_sent > 700))
            begin
                idle_on   = 1'b0;
                long_hold = 1'b1;
                holds_done++;
            end
            ops = $urandom_range(4, 40);
            repeat (ops)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    idx = item_index_t'($urandom_range(0, 63));
                    send_req(OP_LOAD, idx,
                             wide_phase ? class_id_t'($urandom) : class_for(idx));
                end
                else
                begin
                    send_next();
                end
            end
            phase++;
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

### filelist.f
rtl/dcqe_pkg.sv
rtl/dcqe_stream_if.sv
rtl/dcqe_rank_sort.sv
rtl/distinct_class_quartet_enumerator_unit.sv
sim/dcqe_checker.sv
sim/tb_top.sv
